// ===== hw/rtl/vllm_pkg.sv =====
// ----------------------------------------------------------------------------
// vllm_pkg - shared types and constants of the video loop latency meter
// Item layouts, register indexes, phase codes and tag/marker constants.
// ----------------------------------------------------------------------------
package vllm_pkg;

  // configuration register indexes
  typedef enum logic [1:0] {
    CfgDisplayIndex    = 2'd0,
    CfgLatencyEnable   = 2'd1,
    CfgBlackFrameCount = 2'd2
  } cfg_idx_e;

  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CfgDataW  = 8;

  // measurement phase codes
  localparam logic [2:0] PhIdle  = 3'd0;
  localparam logic [2:0] PhBlack = 3'd1;
  localparam logic [2:0] PhLatch = 3'd2;
  localparam logic [2:0] PhWait  = 3'd3;
  localparam logic [2:0] PhRead  = 3'd4;

  localparam logic [15:0] TagWhite        = 16'hf0f0;
  localparam logic [7:0]  LevelBlack      = 8'd10;
  localparam logic [7:0]  LevelWhite      = 8'd240;
  localparam logic [7:0]  RedBase         = 8'd10;
  localparam logic [7:0]  BlackCountReset = 8'd10;
  localparam logic [15:0] FrameMax        = 16'hffff;
  localparam logic [31:0] CountMax        = 32'hffff_ffff;
  localparam logic [47:0] SumMax          = 48'hffff_ffff_ffff;

  typedef struct packed {
    logic        cmd;
    logic [31:0] timestamp;
    logic [23:0] grab_pixel;
  } in_item_t;

  typedef struct packed {
    logic        marker_valid;
    logic [7:0]  marker_red;
    logic [7:0]  marker_level;
    logic        from_this_display;
    logic [31:0] current_latency;
    logic [31:0] minimum_latency;
    logic [31:0] maximum_latency;
    logic [47:0] latency_sum;
    logic [31:0] sample_count;
    logic [15:0] latency_in_frames;
  } out_item_t;

endpackage

// ===== hw/rtl/vllm_stream_if.sv =====
// ----------------------------------------------------------------------------
// vllm_stream_if - valid/ready stream channel
// Carries one payload per transfer; a transfer happens when valid and ready
// are both high at a rising clock edge.
// ----------------------------------------------------------------------------
interface vllm_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/vllm_in_stage.sv =====
// ----------------------------------------------------------------------------
// vllm_in_stage - input register
// Holds one accepted item until the core takes it; refills in the same cycle.
// ----------------------------------------------------------------------------
module vllm_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  vllm_pkg::in_item_t in_item_i,
  input  logic               take_i,
  output logic               valid_o,
  output vllm_pkg::in_item_t item_o
);

  logic               valid_q;
  vllm_pkg::in_item_t item_q;

  assign in_ready_o = !valid_q || take_i;
  assign valid_o    = valid_q;
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

endmodule

// ===== hw/rtl/vllm_core.sv =====
// ----------------------------------------------------------------------------
// vllm_core - measurement state and statistics
// Configuration registers, tag sequencer and latency statistics. Computes
// the result of the presented item and commits the new state on take.
// ----------------------------------------------------------------------------
module vllm_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [vllm_pkg::CfgIndexW-1:0]      cfg_index_i,
  input  logic [vllm_pkg::CfgDataW-1:0]       cfg_data_i,
  input  vllm_pkg::in_item_t                  item_i,
  input  logic                                take_i,
  output vllm_pkg::out_item_t                 result_o
);

  logic [3:0]  display_index_q;
  logic        enable_q;
  logic [7:0]  black_count_q;

  logic [2:0]  phase_q, phase_d;
  logic [7:0]  countdown_q, countdown_d;
  logic [31:0] start_time_q, start_time_d;
  logic [15:0] frame_counter_q, frame_counter_d;
  logic [31:0] last_q, last_d;
  logic [31:0] min_q, min_d;
  logic [31:0] max_q, max_d;
  logic [47:0] sum_q, sum_d;
  logic [31:0] count_q, count_d;
  logic [15:0] frames_q, frames_d;

  logic [2:0]  ph;
  logic [7:0]  red;
  logic [31:0] lat;
  logic [48:0] sum_ext;
  logic [7:0]  cd_dec;
  logic        idx_match;

  always_comb begin
    ph        = (phase_q > vllm_pkg::PhRead) ? vllm_pkg::PhIdle : phase_q;
    red       = vllm_pkg::RedBase + {4'b0, display_index_q};
    lat       = item_i.timestamp - start_time_q;
    sum_ext   = {1'b0, sum_q} + {17'b0, lat};
    cd_dec    = countdown_q - 8'd1;
    idx_match = (item_i.grab_pixel[7:0] == red);

    phase_d         = phase_q;
    countdown_d     = countdown_q;
    start_time_d    = start_time_q;
    frame_counter_d = frame_counter_q;
    last_d          = last_q;
    min_d           = min_q;
    max_d           = max_q;
    sum_d           = sum_q;
    count_d         = count_q;
    frames_d        = frames_q;

    result_o = '0;

    if (enable_q) begin
      if (!item_i.cmd) begin
        unique case (ph)
          vllm_pkg::PhIdle: begin
            countdown_d     = black_count_q;
            start_time_d    = '0;
            frame_counter_d = 16'd1;
            phase_d         = vllm_pkg::PhBlack;
          end
          vllm_pkg::PhBlack: begin
            countdown_d           = cd_dec;
            result_o.marker_valid = 1'b1;
            result_o.marker_red   = red;
            result_o.marker_level = vllm_pkg::LevelBlack;
            if (cd_dec == 8'd0) begin
              phase_d = vllm_pkg::PhLatch;
            end
          end
          vllm_pkg::PhLatch: begin
            result_o.marker_valid = 1'b1;
            result_o.marker_red   = red;
            result_o.marker_level = vllm_pkg::LevelWhite;
            start_time_d          = item_i.timestamp;
            frame_counter_d       = 16'd1;
            phase_d               = vllm_pkg::PhWait;
          end
          vllm_pkg::PhWait: begin
            result_o.marker_valid = 1'b1;
            result_o.marker_red   = red;
            result_o.marker_level = vllm_pkg::LevelWhite;
            if (frame_counter_q != vllm_pkg::FrameMax) begin
              frame_counter_d = frame_counter_q + 16'd1;
            end
          end
          default: begin
            // reading: close out one measurement
            if (min_q == 32'd0 || lat < min_q) begin
              min_d = lat;
            end
            if (lat > max_q) begin
              max_d = lat;
            end
            last_d   = lat;
            sum_d    = sum_ext[48] ? vllm_pkg::SumMax : sum_ext[47:0];
            if (count_q != vllm_pkg::CountMax) begin
              count_d = count_q + 32'd1;
            end
            frames_d = frame_counter_q;
            phase_d  = vllm_pkg::PhIdle;
          end
        endcase
      end else if (ph == vllm_pkg::PhWait) begin
        result_o.from_this_display = idx_match;
        if (idx_match && item_i.grab_pixel[23:8] == vllm_pkg::TagWhite) begin
          phase_d = vllm_pkg::PhRead;
        end
      end

      result_o.current_latency   = last_d;
      result_o.minimum_latency   = min_d;
      result_o.maximum_latency   = max_d;
      result_o.latency_sum       = sum_d;
      result_o.sample_count      = count_d;
      result_o.latency_in_frames = frames_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      display_index_q <= '0;
      enable_q        <= 1'b0;
      black_count_q   <= vllm_pkg::BlackCountReset;
      phase_q         <= vllm_pkg::PhIdle;
      countdown_q     <= '0;
      start_time_q    <= '0;
      frame_counter_q <= '0;
      last_q          <= '0;
      min_q           <= '0;
      max_q           <= '0;
      sum_q           <= '0;
      count_q         <= '0;
      frames_q        <= '0;
    end else if (cfg_we_i) begin
      unique case (vllm_pkg::cfg_idx_e'(cfg_index_i))
        vllm_pkg::CfgDisplayIndex: begin
          display_index_q <= cfg_data_i[3:0];
        end
        vllm_pkg::CfgLatencyEnable: begin
          // enable write restarts the measurement from scratch
          enable_q        <= cfg_data_i[0];
          phase_q         <= vllm_pkg::PhIdle;
          countdown_q     <= '0;
          start_time_q    <= '0;
          frame_counter_q <= '0;
          last_q          <= '0;
          min_q           <= '0;
          max_q           <= '0;
          sum_q           <= '0;
          count_q         <= '0;
          frames_q        <= '0;
        end
        vllm_pkg::CfgBlackFrameCount: begin
          black_count_q <= cfg_data_i;
        end
        default: begin
        end
      endcase
    end else if (take_i) begin
      phase_q         <= phase_d;
      countdown_q     <= countdown_d;
      start_time_q    <= start_time_d;
      frame_counter_q <= frame_counter_d;
      last_q          <= last_d;
      min_q           <= min_d;
      max_q           <= max_d;
      sum_q           <= sum_d;
      count_q         <= count_d;
      frames_q        <= frames_d;
    end
  end

endmodule

// ===== hw/rtl/vllm_out_stage.sv =====
// ----------------------------------------------------------------------------
// vllm_out_stage - result register
// Holds one result until the sink takes it; reloads in the same cycle.
// ----------------------------------------------------------------------------
module vllm_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  vllm_pkg::out_item_t result_i,
  output logic                free_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output vllm_pkg::out_item_t out_item_o
);

  logic                valid_q;
  vllm_pkg::out_item_t res_q;

  assign free_o      = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_item_o  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

endmodule

// ===== hw/rtl/video_loop_latency_meter_unit.sv =====
// ----------------------------------------------------------------------------
// video_loop_latency_meter_unit - display-to-capture latency meter
// Tags presented frames and measures the time until the tag is grabbed back.
// ----------------------------------------------------------------------------
// Takes one item per clock and gives one result per item. An accepted item
// sits in the input register while the core computes its result
// combinationally; the result loads the result register when the core takes
// the item, and the phase and statistics registers are updated at that same
// edge. The rate is one item per cycle while the result register can be
// freed; back pressure on the result side stalls the input only once both
// registers are full. Configuration writes take effect at once and must be
// issued while no item is in flight.
module video_loop_latency_meter_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  vllm_stream_if.sink                    in_i,
  vllm_stream_if.source                  out_o,
  input  logic                           cfg_we_i,
  input  logic [vllm_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [vllm_pkg::CfgDataW-1:0]  cfg_data_i
);

  logic                s1_valid;
  vllm_pkg::in_item_t  s1_item;
  vllm_pkg::out_item_t result;
  logic                out_free;
  logic                take;

  assign take = s1_valid && out_free;

  vllm_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .in_item_i  (in_i.payload),
    .take_i     (take),
    .valid_o    (s1_valid),
    .item_o     (s1_item)
  );

  vllm_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .item_i      (s1_item),
    .take_i      (take),
    .result_o    (result)
  );

  vllm_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (take),
    .result_i    (result),
    .free_o      (out_free),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_item_o  (out_o.payload)
  );

endmodule

// ===== hw/rtl/vllm_checker.sv =====
// ----------------------------------------------------------------------------
// vllm_checker - port-level checks of the latency meter
// Watches the result channel and checks marker and statistics consistency.
// ----------------------------------------------------------------------------
module vllm_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  vllm_pkg::out_item_t out_payload_i
);

  // a result waiting for the sink stays up
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // drawn markers carry a known level and the display red offset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_payload_i.marker_valid |->
      (out_payload_i.marker_level == vllm_pkg::LevelBlack ||
       out_payload_i.marker_level == vllm_pkg::LevelWhite) &&
      out_payload_i.marker_red >= vllm_pkg::RedBase &&
      !out_payload_i.from_this_display)
    else $error("bad marker result");

  // no marker means blank marker fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_payload_i.marker_valid |->
      out_payload_i.marker_red == 8'd0 && out_payload_i.marker_level == 8'd0)
    else $error("marker fields set without marker");

  // without samples all statistics read zero; with samples min <= max
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_payload_i.sample_count == 32'd0 |->
      out_payload_i.current_latency == 32'd0 &&
      out_payload_i.minimum_latency == 32'd0 &&
      out_payload_i.maximum_latency == 32'd0 &&
      out_payload_i.latency_sum == 48'd0 &&
      out_payload_i.latency_in_frames == 16'd0)
    else $error("statistics set without samples");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_payload_i.minimum_latency <= out_payload_i.maximum_latency)
    else $error("minimum above maximum");

endmodule

bind video_loop_latency_meter_unit vllm_checker u_vllm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_payload_i (out_o.payload)
);
